/* hw/rtl/avih_pkg.sv */
`default_nettype none

package avih_pkg;

	localparam int HEADER_LEN         = 310;
	localparam int CHUNK_HEADER_LEN   = 8;
	localparam int ENTRY_BYTES        = 16;
	localparam int SIZE_TABLE_ENTRIES = 25;

	localparam logic [31:0] MARK_VIDEO = 32'h6364_3030;
	localparam logic [31:0] MARK_AUDIO = 32'h6277_3130;

	localparam int ENT_W  = 17;
	localparam int MF_W   = 15;
	localparam int DVD_W  = 21;
	localparam int DVS_W  = 9;
	localparam int USEC_W = 20;

	localparam logic [DVD_W-1:0]  USECS_NUM      = 21'd2000000;
	localparam logic [USEC_W-1:0] USECS_ZERO_FPS = 20'd1000000;

	localparam logic [1:0] FUNC_BEGIN = 2'd0;
	localparam logic [1:0] FUNC_CHUNK = 2'd1;
	localparam logic [1:0] FUNC_CLOSE = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	localparam logic [1:0] KIND_BEGIN  = 2'd0;
	localparam logic [1:0] KIND_ENTRY  = 2'd1;
	localparam logic [1:0] KIND_HEADER = 2'd2;
	localparam logic [1:0] KIND_FULL   = 2'd3;

	localparam logic [1:0] CFG_MAX_FRAMES = 2'd0;
	localparam logic [1:0] CFG_AUDIO_HZ   = 2'd1;
	localparam logic [1:0] CFG_AUDIO_EN   = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic        ctx;
		logic [31:0] size;
		logic        is_video;
		logic [15:0] frames;
		logic [7:0]  fps;
		logic [4:0]  ftype;
	} item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [31:0]       marker;
		logic [31:0]       offset;
		logic [31:0]       csize;
		logic [31:0]       riff;
		logic [31:0]       movi;
		logic [31:0]       index;
		logic [30:0]       samples;
		logic [1:0]        streams;
		logic [USEC_W-1:0] usecs;
		logic [15:0]       width;
		logic [15:0]       height;
	} result_t;

	typedef struct packed {
		logic [MF_W-1:0] max_frames;
		logic            audio_en;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [15:0] width;
		logic [15:0] height;
	} dims_t;

	function automatic dims_t frame_dims(input logic [4:0] ft);
		dims_t d;
		case (ft)
			5'd0:    d = '{16'd96,   16'd96};
			5'd1:    d = '{16'd160,  16'd120};
			5'd2:    d = '{16'd128,  16'd128};
			5'd3:    d = '{16'd176,  16'd144};
			5'd4:    d = '{16'd240,  16'd176};
			5'd5:    d = '{16'd240,  16'd240};
			5'd6:    d = '{16'd320,  16'd240};
			5'd7:    d = '{16'd320,  16'd320};
			5'd8:    d = '{16'd400,  16'd296};
			5'd9:    d = '{16'd480,  16'd320};
			5'd10:   d = '{16'd640,  16'd480};
			5'd11:   d = '{16'd800,  16'd600};
			5'd12:   d = '{16'd1024, 16'd768};
			5'd13:   d = '{16'd1280, 16'd720};
			5'd14:   d = '{16'd1280, 16'd1024};
			5'd15:   d = '{16'd1600, 16'd1200};
			5'd16:   d = '{16'd920,  16'd1080};
			5'd17:   d = '{16'd720,  16'd1280};
			5'd18:   d = '{16'd864,  16'd1536};
			5'd19:   d = '{16'd2048, 16'd1536};
			5'd20:   d = '{16'd2560, 16'd1440};
			5'd21:   d = '{16'd2560, 16'd1600};
			5'd22:   d = '{16'd1080, 16'd1920};
			5'd23:   d = '{16'd2560, 16'd1920};
			5'd24:   d = '{16'd2592, 16'd1944};
			default: d = '{16'd0,    16'd0};
		endcase
		if (32'(ft) >= SIZE_TABLE_ENTRIES) begin
			d = '{16'd0, 16'd0};
		end
		return d;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/avih_div.sv */
`default_nettype none

module avih_div (
	input  wire                clk,
	input  wire                arst_n,
	input  avih_pkg::div_req_t req,
	output avih_pkg::div_rsp_t rsp
);
	import avih_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/avih_fifo.sv */
`default_nettype none

module avih_fifo #(
	parameter int DEPTH = 4
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push_valid,
	output logic            push_ready,
	input  avih_pkg::item_t push_item,
	output logic            pop_valid,
	input  wire             pop_ready,
	output avih_pkg::item_t pop_item
);
	import avih_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/avih_front.sv */
`default_nettype none

module avih_front (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_tvalid,
	output logic            s_tready,
	input  wire [63:0]      s_tdata,
	input  wire [3:0]       s_tuser,
	output logic            push_valid,
	input  wire             push_ready,
	output avih_pkg::item_t push_item
);
	import avih_pkg::*;

	logic  vld_s1;
	item_t item_s1;

	assign s_tready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	// Items with an unknown function are taken and dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid && (s_tuser[1:0] != FUNC_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op       <= s_tuser[1:0];
			item_s1.ctx      <= s_tuser[2];
			item_s1.is_video <= s_tuser[3];
			item_s1.size     <= s_tdata[31:0];
			item_s1.frames   <= s_tdata[47:32];
			item_s1.fps      <= s_tdata[55:48];
			item_s1.ftype    <= s_tdata[60:56];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/avih_back.sv */
`default_nettype none

module avih_back (
	input  wire               clk,
	input  wire               arst_n,
	input  avih_pkg::cfg_t    cfg,
	input  wire               pop_valid,
	output logic              pop_ready,
	input  avih_pkg::item_t   item,
	output logic              m_tvalid,
	input  wire               m_tready,
	output avih_pkg::result_t res
);
	import avih_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HDR  = 2'd2;

	logic [1:0]       state_q;
	logic [31:0]      movie_q [2];
	logic [31:0]      offs_q  [2];
	logic [ENT_W-1:0] ents_q  [2];
	logic [31:0]      abytes_q;
	logic [ENT_W-1:0] achunks_q;
	logic             out_vld_q;
	result_t          res_q;

	logic             wctx_q;
	logic [15:0]      wframes_q;
	logic [4:0]       wftype_q;
	logic             wfps_zero_q;

	logic             out_free;
	logic             pop;
	logic             produce;
	logic             hdr_go;
	logic [ENT_W-1:0] cap;
	logic             full;
	logic [ENT_W-1:0] aud;
	logic [ENT_W:0]   chunks;
	logic             has_audio;
	dims_t            dims;
	result_t          res_d;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign out_free  = !out_vld_q || m_tready;
	assign pop       = (state_q == ST_IDLE) && pop_valid && out_free;
	assign pop_ready = pop;
	assign hdr_go    = (state_q == ST_HDR) && out_free;
	assign m_tvalid  = out_vld_q;
	assign res       = res_q;

	assign cap  = item.ctx ? ENT_W'(cfg.max_frames) + ENT_W'(1)
	                       : ENT_W'({cfg.max_frames, 1'b0}) + ENT_W'(7);
	assign full = ents_q[item.ctx] >= cap;

	assign aud       = wctx_q ? '0 : achunks_q;
	assign chunks    = (ENT_W + 1)'(wframes_q) + (ENT_W + 1)'(aud);
	assign has_audio = cfg.audio_en && (aud != '0);
	assign dims      = frame_dims(wftype_q);

	assign div_req.start    = pop && (item.op == FUNC_CLOSE);
	assign div_req.dividend = USECS_NUM + DVD_W'(item.fps);
	assign div_req.divisor  = {item.fps, 1'b0};

	avih_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		res_d   = '0;
		produce = 1'b0;
		if (pop) begin
			case (item.op)
				FUNC_BEGIN: begin
					produce    = 1'b1;
					res_d.kind = KIND_BEGIN;
				end
				FUNC_CHUNK: begin
					produce = 1'b1;
					if (full) begin
						res_d.kind = KIND_FULL;
					end else begin
						res_d.kind   = KIND_ENTRY;
						res_d.marker = item.is_video ? MARK_VIDEO : MARK_AUDIO;
						res_d.offset = offs_q[item.ctx];
						res_d.csize  = item.size;
					end
				end
				default: begin
				end
			endcase
		end
		if (hdr_go) begin
			produce       = 1'b1;
			res_d.kind    = KIND_HEADER;
			res_d.riff    = movie_q[wctx_q] + 32'(HEADER_LEN)
			                + 32'({chunks, 4'b0}) + 32'({chunks, 3'b0});
			res_d.movi    = movie_q[wctx_q] + 32'({chunks, 3'b0}) + 32'd4;
			res_d.index   = 32'({chunks, 4'b0});
			res_d.samples = has_audio ? abytes_q[31:1] : '0;
			res_d.streams = has_audio ? 2'd2 : 2'd1;
			res_d.usecs   = wfps_zero_q ? USECS_ZERO_FPS : div_rsp.quotient[USEC_W-1:0];
			res_d.width   = dims.width;
			res_d.height  = dims.height;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				movie_q[c] <= '0;
				offs_q[c]  <= 32'd4;
				ents_q[c]  <= '0;
			end
			abytes_q  <= '0;
			achunks_q <= '0;
		end else begin
			if (produce) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (item.op)
							FUNC_BEGIN: begin
								movie_q[item.ctx] <= '0;
								offs_q[item.ctx]  <= 32'd4;
								ents_q[item.ctx]  <= '0;
								if (!item.ctx) begin
									abytes_q  <= '0;
									achunks_q <= '0;
								end
							end
							FUNC_CHUNK: begin
								if (!full) begin
									movie_q[item.ctx] <= movie_q[item.ctx] + item.size;
									offs_q[item.ctx]  <= offs_q[item.ctx] + item.size
									                     + 32'(CHUNK_HEADER_LEN);
									ents_q[item.ctx]  <= ents_q[item.ctx] + 1'b1;
									if (!item.is_video && !item.ctx) begin
										abytes_q  <= abytes_q + item.size;
										achunks_q <= achunks_q + 1'b1;
									end
								end
							end
							FUNC_CLOSE: begin
								state_q <= ST_DIV;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_HDR;
					end
				end
				ST_HDR: begin
					if (hdr_go) begin
						movie_q[wctx_q] <= '0;
						offs_q[wctx_q]  <= 32'd4;
						ents_q[wctx_q]  <= '0;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			res_q <= res_d;
		end
		if (div_req.start) begin
			wctx_q      <= item.ctx;
			wframes_q   <= item.frames;
			wftype_q    <= item.ftype;
			wfps_zero_q <= item.fps == '0;
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready |-> (state_q == ST_IDLE))
		else $error("queue popped while a close is in progress");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_hdr_return: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_go |=> (state_q == ST_IDLE) && out_vld_q && (res_q.kind == KIND_HEADER))
		else $error("header result not delivered on close");

	a_close_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(div_req.start && !m_tready && !out_vld_q) |=> !out_vld_q)
		else $error("close produced a result before the divide");

endmodule

`default_nettype wire

/* hw/rtl/avi_index_and_header_builder_core.sv */
// AVI idx1 index and header builder.
// Input stream s_*: one transaction per event (begin, add chunk, close) for the
// motion or timelapse context. Output stream m_*: one transaction per event,
// except that events with an unknown function are taken and produce nothing.
// Add chunk returns an index entry, or a refusal when the context's index is
// full; begin returns an acknowledge; close returns the header values.
// Begin and add chunk pass the input register, the queue and the output register,
// and sustain one event per cycle while m_tready is high and no close is pending.
// Close holds the back end for a bit-serial divide of the microseconds per frame.
// A small queue between the input stage and the back end keeps accepting
// events while a close is in progress, until it fills.
// The output register holds a result until m_tready; the back end stalls
// behind it and the queue then stalls the input.
// The cfg_* channel writes max_frames, the audio rate and audio_enabled; it is
// always ready and is to be used only while the block is idle. The audio rate
// is accepted and not kept, as no result carries it.
// Reset clears both contexts, the audio totals and the queue, and loads the
// register defaults of 1000 frames and audio enabled.

`default_nettype none

module avi_index_and_header_builder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire [63:0]   s_tdata,  // data_size, frame_count, fps, frame_type, zero fill
	input  wire [3:0]    s_tuser,  // func, context_req, is_video
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [279:0] m_tdata,  // chunk_marker, chunk_offset, chunk_size, riff_size,
	                               // movi_list_size, index_size, audio_samples,
	                               // stream_count, frame_period_us, frame_width,
	                               // frame_height, zero fill
	output logic [1:0]   m_tuser,  // result_kind
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire [1:0]    cfg_index,
	input  wire [15:0]   cfg_data
);
	import avih_pkg::*;

	cfg_t    cfg_q;
	logic    push_valid;
	logic    push_ready;
	item_t   push_item;
	logic    pop_valid;
	logic    pop_ready;
	item_t   pop_item;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frames <= MF_W'(1000);
			cfg_q.audio_en   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_FRAMES: cfg_q.max_frames <= cfg_data[MF_W-1:0];
				CFG_AUDIO_EN:   cfg_q.audio_en   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	avih_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	avih_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	avih_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.item      (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {3'b000, res.height, res.width, res.usecs, res.streams, res.samples,
	                  res.index, res.movi, res.riff, res.csize, res.offset, res.marker};

endmodule

`default_nettype wire

/* verif/avi_index_and_header_builder_core_tb.sv */
`timescale 1ns / 100ps

module avi_index_and_header_builder_core_tb;

	import avih_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 40;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_SPARSE,
		RDY_BURSTY
	} rdy_mode_t;

	typedef struct {
		bit          is_wr;
		logic [1:0]  reg_idx;
		logic [15:0] reg_val;
		item_t       it;
		bit          typed;
		result_t     want;
	} dir_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	wire           s_tready;
	logic [63:0]   s_tdata = '0;
	logic [3:0]    s_tuser = '0;
	wire           m_tvalid;
	logic          m_tready = 1'b0;
	wire  [279:0]  m_tdata;
	wire  [1:0]    m_tuser;
	logic          cfg_valid = 1'b0;
	wire           cfg_ready;
	logic [1:0]    cfg_index = '0;
	logic [15:0]   cfg_data = '0;

	logic [14:0]   max_frames_r = 15'd1000;
	logic          audio_en_r = 1'b1;
	logic [31:0]   movie_total [2] = '{32'd0, 32'd0};
	logic [31:0]   chunk_pos [2] = '{32'd4, 32'd4};
	logic [16:0]   entries_used [2] = '{17'd0, 17'd0};
	logic [31:0]   audio_total = '0;
	logic [16:0]   audio_count = '0;

	logic [15:0]   frame_w_tab [25] = '{
		96, 160, 128, 176, 240, 240, 320, 320, 400, 480, 640, 800, 1024,
		1280, 1280, 1600, 920, 720, 864, 2048, 2560, 2560, 1080, 2560, 2592
	};
	logic [15:0]   frame_h_tab [25] = '{
		96, 120, 128, 144, 176, 240, 240, 320, 296, 320, 480, 600, 768,
		720, 1024, 1200, 1080, 1280, 1536, 1536, 1440, 1600, 1920, 1920, 1944
	};

	result_t       avi_result_q [$];
	int            fail_count = 0;
	int            stim_count = 0;
	int            burst_left = 0;
	int            cycle_cnt = 0;
	int            rdy_left = 0;
	rdy_mode_t     rdy_mode = RDY_ALWAYS;

	avi_index_and_header_builder_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_recording(input logic ctx);
		movie_total[ctx] = '0;
		chunk_pos[ctx] = 32'd4;
		entries_used[ctx] = '0;
	endfunction

	function automatic bit build_avi_result(input item_t it, output result_t r);
		logic [31:0] cap;
		logic [31:0] aud;
		logic [31:0] chunks;
		logic [31:0] usecs;
		bit          has_audio;
		r = '0;
		case (it.op)
			FUNC_BEGIN: begin
				clear_recording(it.ctx);
				if (it.ctx == 1'b0) begin
					audio_total = '0;
					audio_count = '0;
				end
				r.kind = KIND_BEGIN;
				return 1'b1;
			end
			FUNC_CHUNK: begin
				cap = it.ctx ? 32'(max_frames_r) + 32'd1 : 32'd2 * 32'(max_frames_r) + 32'd7;
				if (32'(entries_used[it.ctx]) >= cap) begin
					r.kind = KIND_FULL;
					return 1'b1;
				end
				r.kind = KIND_ENTRY;
				r.marker = it.is_video ? MARK_VIDEO : MARK_AUDIO;
				r.offset = chunk_pos[it.ctx];
				r.csize = it.size;
				movie_total[it.ctx] = movie_total[it.ctx] + it.size;
				chunk_pos[it.ctx] = chunk_pos[it.ctx] + it.size + 32'(CHUNK_HEADER_LEN);
				entries_used[it.ctx] = entries_used[it.ctx] + 17'd1;
				if (!it.is_video && it.ctx == 1'b0) begin
					audio_total = audio_total + it.size;
					audio_count = audio_count + 17'd1;
				end
				return 1'b1;
			end
			FUNC_CLOSE: begin
				aud = it.ctx ? 32'd0 : 32'(audio_count);
				chunks = 32'(it.frames) + aud;
				has_audio = audio_en_r && (aud != 32'd0);
				if (it.fps == 8'd0) begin
					usecs = 32'd1000000;
				end else begin
					usecs = (32'd2000000 + 32'(it.fps)) / (32'd2 * 32'(it.fps));
				end
				r.kind = KIND_HEADER;
				r.riff = movie_total[it.ctx] + 32'(HEADER_LEN)
					+ 32'(CHUNK_HEADER_LEN + ENTRY_BYTES) * chunks;
				r.movi = movie_total[it.ctx] + 32'(CHUNK_HEADER_LEN) * chunks + 32'd4;
				r.index = 32'(ENTRY_BYTES) * chunks;
				r.samples = has_audio ? audio_total[31:1] : 31'd0;
				r.streams = has_audio ? 2'd2 : 2'd1;
				r.usecs = usecs[USEC_W-1:0];
				if (32'(it.ftype) < SIZE_TABLE_ENTRIES) begin
					r.width = frame_w_tab[it.ftype];
					r.height = frame_h_tab[it.ftype];
				end
				clear_recording(it.ctx);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic item_t mk_item(input logic [1:0] op, input logic ctx,
			input logic [31:0] size, input logic vid, input logic [15:0] frames,
			input logic [7:0] fps, input logic [4:0] ft);
		item_t it;
		it.op = op;
		it.ctx = ctx;
		it.size = size;
		it.is_video = vid;
		it.frames = frames;
		it.fps = fps;
		it.ftype = ft;
		return it;
	endfunction

	function automatic item_t rand_item(input logic [1:0] op, input logic ctx);
		int sel;
		logic [31:0] size;
		sel = $urandom_range(0, 7);
		if (sel == 0) begin
			size = 32'd0;
		end else if (sel == 1) begin
			size = 32'hFFFF_FFFF;
		end else if (sel < 4) begin
			size = 32'($urandom_range(0, 4096));
		end else begin
			size = $urandom;
		end
		return mk_item(op, ctx, size, 1'($urandom), 16'($urandom),
			($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom), 5'($urandom));
	endfunction

	function automatic result_t res_of(input logic [1:0] kind);
		result_t r;
		r = '0;
		r.kind = kind;
		return r;
	endfunction

	function automatic result_t res_entry(input logic [31:0] marker,
			input logic [31:0] offset, input logic [31:0] size);
		result_t r;
		r = res_of(KIND_ENTRY);
		r.marker = marker;
		r.offset = offset;
		r.csize = size;
		return r;
	endfunction

	function automatic dir_row_t ev(input item_t it, input bit typed, input result_t want);
		dir_row_t row;
		row.is_wr = 1'b0;
		row.reg_idx = '0;
		row.reg_val = '0;
		row.it = it;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic dir_row_t wr(input logic [1:0] idx, input logic [15:0] val);
		dir_row_t row;
		row = ev('0, 1'b0, '0);
		row.is_wr = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	task automatic send_ev(input item_t it, input bit typed, input result_t want);
		result_t pred;
		bit      has_res;
		int      gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, it.ftype, it.fps, it.frames, it.size};
		s_tuser <= {it.is_video, it.ctx, it.op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		has_res = build_avi_result(it, pred);
		if (has_res) begin
			avi_result_q.push_back(typed ? want : pred);
		end
		if (it.op != FUNC_NONE) begin
			stim_count++;
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (avi_result_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_MAX_FRAMES: max_frames_r = val[14:0];
			CFG_AUDIO_EN:   audio_en_r = val[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [14:0] mf, input logic [15:0] rate, input logic aen);
		wait_idle();
		write_reg(CFG_MAX_FRAMES, {1'b0, mf});
		write_reg(CFG_AUDIO_HZ, rate);
		write_reg(CFG_AUDIO_EN, {15'd0, aen});
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random_phase(input int target);
		int   start;
		int   n;
		int   pick;
		logic ctx;
		start = stim_count;
		while (stim_count - start < target) begin
			pick = $urandom_range(0, 99);
			ctx = 1'($urandom);
			if (pick < 3) begin
				wait_idle();
			end else if (pick < 83) begin
				send_ev(rand_item(FUNC_BEGIN, ctx), 1'b0, '0);
				if (max_frames_r <= 15'd3) begin
					n = $urandom_range(0, 2 * int'(max_frames_r) + 10);
				end else begin
					n = $urandom_range(0, 12);
				end
				repeat (n) begin
					send_ev(rand_item(FUNC_CHUNK, ($urandom_range(0, 9) == 0) ? !ctx : ctx),
						1'b0, '0);
				end
				if (pick < 75) begin
					send_ev(rand_item(FUNC_CLOSE, ctx), 1'b0, '0);
				end
			end else begin
				send_ev(rand_item(2'($urandom), ctx), 1'b0, '0);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
			rdy_left <= $urandom_range(16, 96);
		end else begin
			rdy_left <= rdy_left - 1;
		end
		case (rdy_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_COIN:   m_tready <= 1'($urandom);
			RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:    m_tready <= (rdy_left % 20 == 0);
		endcase
	end

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (avi_result_q.size() == 0) begin
				$error("result transaction with no expected result, kind %0d", m_tuser);
				fail_count++;
			end else begin
				want = avi_result_q.pop_front();
				check_field("result_kind", 32'(want.kind), 32'(m_tuser));
				check_field("chunk_marker", want.marker, m_tdata[31:0]);
				check_field("chunk_offset", want.offset, m_tdata[63:32]);
				check_field("chunk_size", want.csize, m_tdata[95:64]);
				check_field("riff_size", want.riff, m_tdata[127:96]);
				check_field("movi_list_size", want.movi, m_tdata[159:128]);
				check_field("index_size", want.index, m_tdata[191:160]);
				check_field("audio_samples", 32'(want.samples), 32'(m_tdata[222:192]));
				check_field("stream_count", 32'(want.streams), 32'(m_tdata[224:223]));
				check_field("frame_period_us", 32'(want.usecs), 32'(m_tdata[244:225]));
				check_field("frame_width", 32'(want.width), 32'(m_tdata[260:245]));
				check_field("frame_height", 32'(want.height), 32'(m_tdata[276:261]));
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		dir_row_t rows [$];
		result_t  hdr;
		int       p;

		hdr = res_of(KIND_HEADER);
		hdr.riff = 32'd310;
		hdr.movi = 32'd4;
		hdr.streams = 2'd1;
		hdr.usecs = 20'd3922;
		hdr.width = 16'd2592;
		hdr.height = 16'd1944;

		rows.push_back(ev(mk_item(FUNC_BEGIN, 1'b0, 32'd0, 1'b0, 16'd0, 8'd0, 5'd0),
			1'b1, res_of(KIND_BEGIN)));
		rows.push_back(ev(mk_item(FUNC_CHUNK, 1'b0, 32'd0, 1'b1, 16'd0, 8'd0, 5'd0),
			1'b1, res_entry(MARK_VIDEO, 32'd4, 32'd0)));
		rows.push_back(ev(mk_item(FUNC_CHUNK, 1'b0, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 8'hFF,
			5'h1F), 1'b1, res_entry(MARK_AUDIO, 32'd12, 32'hFFFF_FFFF)));
		rows.push_back(ev(mk_item(FUNC_CHUNK, 1'b0, 32'hFFFF_FFFF, 1'b1, 16'd0, 8'd1, 5'd0),
			1'b0, '0));
		rows.push_back(ev(mk_item(FUNC_NONE, 1'b1, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'hFF,
			5'h1F), 1'b0, '0));
		rows.push_back(ev(mk_item(FUNC_CLOSE, 1'b0, 32'd0, 1'b1, 16'hFFFF, 8'd0, 5'd31),
			1'b0, '0));
		rows.push_back(ev(mk_item(FUNC_CLOSE, 1'b1, 32'd7, 1'b0, 16'd0, 8'd255, 5'd24),
			1'b1, hdr));
		rows.push_back(ev(mk_item(FUNC_BEGIN, 1'b1, 32'd0, 1'b0, 16'd0, 8'd0, 5'd0),
			1'b1, res_of(KIND_BEGIN)));
		rows.push_back(ev(mk_item(FUNC_CHUNK, 1'b1, 32'd100, 1'b0, 16'd0, 8'd0, 5'd0),
			1'b1, res_entry(MARK_AUDIO, 32'd4, 32'd100)));
		rows.push_back(ev(mk_item(FUNC_CLOSE, 1'b1, 32'd0, 1'b0, 16'd1, 8'd1, 5'd0),
			1'b0, '0));
		rows.push_back(ev(mk_item(FUNC_CLOSE, 1'b0, 32'd0, 1'b0, 16'd5, 8'd30, 5'd10),
			1'b0, '0));
		rows.push_back(ev(mk_item(FUNC_CLOSE, 1'b0, 32'hA5A5_5A5A, 1'b1, 16'd0, 8'd2, 5'd25),
			1'b0, '0));
		rows.push_back(wr(CFG_MAX_FRAMES, 16'd0));
		rows.push_back(ev(mk_item(FUNC_BEGIN, 1'b1, 32'd0, 1'b0, 16'd0, 8'd0, 5'd0),
			1'b1, res_of(KIND_BEGIN)));
		rows.push_back(ev(mk_item(FUNC_CHUNK, 1'b1, 32'd5, 1'b1, 16'd0, 8'd0, 5'd0),
			1'b1, res_entry(MARK_VIDEO, 32'd4, 32'd5)));
		rows.push_back(ev(mk_item(FUNC_CHUNK, 1'b1, 32'd5, 1'b1, 16'd0, 8'd0, 5'd0),
			1'b1, res_of(KIND_FULL)));
		rows.push_back(ev(mk_item(FUNC_BEGIN, 1'b0, 32'd0, 1'b0, 16'd0, 8'd0, 5'd0),
			1'b1, res_of(KIND_BEGIN)));
		rows.push_back(wr(CFG_AUDIO_EN, 16'd0));
		rows.push_back(wr(CFG_AUDIO_HZ, 16'hFFFF));
		rows.push_back(ev(mk_item(FUNC_CHUNK, 1'b0, 32'd10, 1'b0, 16'd0, 8'd0, 5'd0),
			1'b0, '0));
		rows.push_back(ev(mk_item(FUNC_CLOSE, 1'b0, 32'd0, 1'b0, 16'hFFFF, 8'd255, 5'd24),
			1'b0, '0));
		rows.push_back(wr(CFG_MAX_FRAMES, 16'h7FFF));
		rows.push_back(wr(CFG_AUDIO_EN, 16'd1));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_wr) begin
				wait_idle();
				write_reg(rows[i].reg_idx, rows[i].reg_val);
				cfg_valid <= 1'b0;
			end else begin
				send_ev(rows[i].it, rows[i].typed, rows[i].want);
			end
		end

		for (p = 0; p < 6; p++) begin
			case (p)
				0: set_regs(15'd1, 16'd0, 1'b1);
				1: set_regs(15'd0, 16'hFFFF, 1'b1);
				2: set_regs(15'h7FFF, 16'hFFFF, 1'b0);
				3: set_regs(15'd2, 16'd8000, 1'b1);
				4: set_regs(15'($urandom_range(0, 5)), 16'($urandom), 1'($urandom));
				default: set_regs(15'd1000, 16'd16000, 1'b1);
			endcase
			run_random_phase(85);
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/avih_pkg.sv
hw/rtl/avih_div.sv
hw/rtl/avih_fifo.sv
hw/rtl/avih_front.sv
hw/rtl/avih_back.sv
hw/rtl/avi_index_and_header_builder_core.sv
verif/avi_index_and_header_builder_core_tb.sv
